/* rtl/core/hnm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hnm_pkg;

  localparam int MAX_SIZE = 512;
  localparam int COORD_W = $clog2(MAX_SIZE);
  localparam int SIZE_W = COORD_W + 1;
  localparam int ADDR_W = 2 * COORD_W;
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int HEIGHT_W = 16;
  localparam int GAIN_W = 12;
  localparam int CFG_W = 12;
  localparam int BYTE_W = 8;
  localparam int NUM_READS = 4;
  localparam int NUM_COMP = 3;
  localparam int SQRT_STEPS = 29;
  localparam int DIV_STEPS = 9;
  localparam int CNT_W = 5;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd819;
  localparam logic [SIZE_W-1:0] MAP_SIZE_RESET = SIZE_W'(MAX_SIZE);

  localparam logic CFG_GAIN = 1'b0;
  localparam logic CFG_MAP_SIZE = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_WRITE,
    OP_READ,
    OP_MULA,
    OP_MULB,
    OP_SQA,
    OP_SQB,
    OP_SUM,
    OP_SQRT,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_DIVSTORE,
    OP_OUTLOAD
  } op_t;

  typedef struct packed {
    op_t op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic oor;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/hnm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module hnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/hnm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module hnm_datapath
  import hnm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic [COORD_W-1:0]  in_col,
  input  wire logic [COORD_W-1:0]  in_row,
  input  wire logic [HEIGHT_W-1:0] in_height,
  input  wire cmd_t                cmd,
  output status_t                  status,
  output logic [BYTE_W-1:0]        nx_r,
  output logic [BYTE_W-1:0]        ny_r,
  output logic [BYTE_W-1:0]        nz_r,
  output logic                     oor_r
);

  localparam int A_W = 30;
  localparam int MAG_W = 28;
  localparam int SQ_W = 2 * MAG_W;
  localparam int V_W = 58;
  localparam int ROOT_W = 30;
  localparam int NUM_W = 41;
  localparam int Q_W = DIV_STEPS;

  logic [GAIN_W-1:0] gain_r;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] live_size;
  logic [COORD_W-1:0] x_r, y_r;
  logic [HEIGHT_W-1:0] hin_r;
  logic [COORD_W-1:0] xl, xr, yd, yu;
  logic oor;
  logic [ADDR_W-1:0] raddr;
  logic [HEIGHT_W-1:0] rdata;
  logic rd_pend_r;
  logic [1:0] rd_idx_r;
  logic signed [HEIGHT_W-1:0] hv_r [NUM_READS];
  logic signed [A_W-1:0] diff, prod, a_r, b_r;
  logic [MAG_W-1:0] mag;
  logic [SQ_W-1:0] sq, asq_r, bsq_r;
  logic [V_W-1:0] v_r, r_r, bit_r, trial;
  logic [ROOT_W-1:0] root;
  logic signed [31:0] comp_c, csum;
  logic [NUM_W-1:0] num, rem_r, dv_r;
  logic [Q_W-1:0] q_r;
  logic [BYTE_W-1:0] qbyte;
  logic [BYTE_W-1:0] nb_r [NUM_COMP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      size_r <= MAP_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN:     gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_MAP_SIZE: size_r <= cfg_wdata[SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (size_r < SIZE_W'(2)) begin
      live_size = SIZE_W'(2);
    end else if (size_r > SIZE_W'(MAX_SIZE)) begin
      live_size = SIZE_W'(MAX_SIZE);
    end else begin
      live_size = size_r;
    end
  end

  always_comb begin
    xl = (x_r == '0) ? COORD_W'(live_size - SIZE_W'(1)) : x_r - COORD_W'(1);
    yd = (y_r == '0) ? COORD_W'(live_size - SIZE_W'(1)) : y_r - COORD_W'(1);
    xr = ({1'b0, x_r} + SIZE_W'(1) == live_size) ? '0 : x_r + COORD_W'(1);
    yu = ({1'b0, y_r} + SIZE_W'(1) == live_size) ? '0 : y_r + COORD_W'(1);
    oor = ({1'b0, x_r} >= live_size) || ({1'b0, y_r} >= live_size);
    unique case (cmd.sel)
      2'd0:    raddr = {y_r, xl};
      2'd1:    raddr = {y_r, xr};
      2'd2:    raddr = {yd, x_r};
      default: raddr = {yu, x_r};
    endcase
  end

  assign status.oor = oor;

  hnm_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.op == OP_WRITE && !oor),
    .waddr({y_r, x_r}),
    .wdata(hin_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= (cmd.op == OP_READ);
    end
  end

  always_comb begin
    if (cmd.op == OP_MULA) begin
      diff = A_W'(hv_r[0]) - A_W'(hv_r[1]);
    end else begin
      diff = A_W'(hv_r[2]) - A_W'(hv_r[3]);
    end
    prod = diff * A_W'($signed({1'b0, gain_r}));
    if (cmd.op == OP_SQA) begin
      mag = a_r[A_W-1] ? MAG_W'(-a_r) : a_r[MAG_W-1:0];
    end else begin
      mag = b_r[A_W-1] ? MAG_W'(-b_r) : b_r[MAG_W-1:0];
    end
    sq = SQ_W'(mag) * SQ_W'(mag);
    trial = r_r + bit_r;
    root = r_r[ROOT_W-1:0];
    unique case (cmd.sel)
      2'd0:    comp_c = 32'(a_r);
      2'd1:    comp_c = 32'(b_r);
      default: comp_c = 32'sd1 <<< 23;
    endcase
    csum = comp_c + 32'($signed({1'b0, root}));
    num = NUM_W'(csum[30:0]) * NUM_W'(510) + NUM_W'({root, 1'b0});
    qbyte = (q_r > Q_W'(255)) ? 8'd255 : q_r[BYTE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      hv_r[rd_idx_r] <= rdata;
    end
    rd_idx_r <= cmd.sel;
    unique case (cmd.op)
      OP_CAPTURE: begin
        x_r <= in_col;
        y_r <= in_row;
        hin_r <= in_height;
      end
      OP_MULA: a_r <= prod;
      OP_MULB: b_r <= prod;
      OP_SQA:  asq_r <= sq;
      OP_SQB:  bsq_r <= sq;
      OP_SUM: begin
        v_r <= V_W'(asq_r) + V_W'(bsq_r) + (V_W'(1) << 46);
        r_r <= '0;
        bit_r <= V_W'(1) << 56;
      end
      OP_SQRT: begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DIVINIT: begin
        rem_r <= num;
        dv_r <= NUM_W'({root, 2'b00}) << (DIV_STEPS - 1);
        q_r <= '0;
      end
      OP_DIVSTEP: begin
        if (rem_r >= dv_r) begin
          rem_r <= rem_r - dv_r;
          q_r <= {q_r[Q_W-2:0], 1'b1};
        end else begin
          q_r <= {q_r[Q_W-2:0], 1'b0};
        end
        dv_r <= dv_r >> 1;
      end
      OP_DIVSTORE: nb_r[cmd.sel] <= qbyte;
      OP_OUTLOAD: begin
        oor_r <= oor;
        nx_r <= oor ? '0 : nb_r[0];
        ny_r <= oor ? '0 : nb_r[1];
        nz_r <= oor ? '0 : nb_r[2];
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/hnm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module hnm_ctrl
  import hnm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  input  wire logic    in_command,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_READ = 7'b0000100,
    S_CALC = 7'b0001000,
    S_SQRT = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    comp_nxt = comp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op = OP_NOP;
    cmd.sel = 2'd0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = OP_CAPTURE;
          cnt_nxt = '0;
          state_nxt = (in_command == CMD_QUERY) ? S_READ : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op = OP_WRITE;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        if (status.oor) begin
          state_nxt = S_OUT;
        end else if (cnt_r == CNT_W'(NUM_READS)) begin
          cnt_nxt = '0;
          state_nxt = S_CALC;
        end else begin
          cmd.op = OP_READ;
          cmd.sel = cnt_r[1:0];
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_CALC: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        unique case (cnt_r)
          CNT_W'(0): cmd.op = OP_MULA;
          CNT_W'(1): cmd.op = OP_MULB;
          CNT_W'(2): cmd.op = OP_SQA;
          CNT_W'(3): cmd.op = OP_SQB;
          default: begin
            cmd.op = OP_SUM;
            cnt_nxt = '0;
            state_nxt = S_SQRT;
          end
        endcase
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_nxt = '0;
          comp_nxt = 2'd0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DIV: begin
        cmd.sel = comp_r;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '0) begin
          cmd.op = OP_DIVINIT;
        end else if (cnt_r <= CNT_W'(DIV_STEPS)) begin
          cmd.op = OP_DIVSTEP;
        end else begin
          cmd.op = OP_DIVSTORE;
          cnt_nxt = '0;
          if (comp_r == 2'(NUM_COMP - 1)) begin
            state_nxt = S_OUT;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op = OP_OUTLOAD;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      comp_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      comp_r <= comp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/height_to_normal_map_core.sv */
// A load request is accepted, then the height store is written.
// A query request, once accepted, runs 4 store reads and one read wait, 5 multiply and sum steps,
// 29 square root steps and 11 divide steps for each of the three components before its result
// can be taken; the next request is accepted at that point too.
// An out-of-range query skips the store reads and the arithmetic and goes straight to the output.
// Reset (synchronous, active low) restores gain and map_size and empties the pipeline;
// the height store is not cleared and holds undefined values until written.
`timescale 1ns / 1ps
`default_nettype none
module height_to_normal_map_core
  import hnm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [39:0]      in_tdata,   // col[8:0], row[17:9], height[33:18], zeros
  input  wire logic             in_tuser,   // command
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [23:0]           out_tdata,  // normal_x[7:0], normal_y[15:8], normal_z[23:16]
  output logic                  out_tuser,  // out_of_range
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  cmd_t cmd;
  status_t status;
  logic [BYTE_W-1:0] nx, ny, nz;

  hnm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_command(in_tuser),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  hnm_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_col   (in_tdata[8:0]),
    .in_row   (in_tdata[17:9]),
    .in_height(in_tdata[33:18]),
    .cmd      (cmd),
    .status   (status),
    .nx_r     (nx),
    .ny_r     (ny),
    .nz_r     (nz),
    .oor_r    (out_tuser)
  );

  assign out_tdata = {nz, ny, nx};

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 24'd0)
    else $error("out-of-range result carries nonzero bytes");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> !$rose(out_tvalid))
    else $error("load request produced a result");

  a_z_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[23:16] >= 8'd128)
    else $error("z byte below midpoint");

endmodule
`default_nettype wire
